// ===== rtl/core/ssdf_pkg.sv =====
// Package for the slice streak and dropout flagger: sizes, register codes, helpers.
`timescale 1ns / 1ps
`default_nettype none
package ssdf_pkg;

    localparam int MAX_STREAK = 8;
    localparam int WIN        = MAX_STREAK + 1;
    localparam int POS_W      = $clog2(WIN);
    localparam int SLICE_W    = 8;
    localparam int COUNT_W    = 4;
    localparam int TOTAL_W    = 12;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HALF_Q15   = 16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STREAK_LENGTH    = 2'd0,
        CFG_STREAK_THRESHOLD = 2'd1,
        CFG_DROP_DIFFERENCE  = 2'd2,
        CFG_DROP_FRACTION    = 2'd3
    } t_cfg_index;

    localparam logic [3:0]  RST_STREAK_LENGTH    = 4'd4;
    localparam logic [15:0] RST_STREAK_THRESHOLD = 16'd9830;
    localparam logic [15:0] RST_DROP_DIFFERENCE  = 16'd22938;
    localparam logic [14:0] RST_DROP_FRACTION    = 15'd1638;

    typedef logic signed [FRAC_W-1:0] t_frac;
    typedef logic [COUNT_W-1:0]       t_count;

    // saturating badness count increment
    function automatic t_count count_add(input t_count c, input logic [1:0] inc);
        logic [COUNT_W:0] s;
        s = {1'b0, c} + {{(COUNT_W-1){1'b0}}, inc};
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

    // saturating volume total accumulate
    function automatic logic [TOTAL_W-1:0] total_add(input logic [TOTAL_W-1:0] t,
                                                     input t_count c);
        logic [TOTAL_W:0] s;
        s = {1'b0, t} + {{(TOTAL_W+1-COUNT_W){1'b0}}, c};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/slice_streak_dropout_flagger.sv =====
// Slice streak and dropout flagger: window of recent slices, badness counts and volume total.
//
//  channel | valid       | stall       | word
//  --------+-------------+-------------+--------------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_fraction, i_slice_valid, i_last_slice
//  out     | o_out_valid | i_out_stall | o_slice_index, o_bad_count, o_volume_bad_total,
//          |             |             | o_last
//  cfg     | i_cfg_we    | -           | i_cfg_index, i_cfg_data
//
// One input word per cycle unless o_in_stall; the window update and all compares finish at
// the accepting edge. A word that is not the top slice yields at most one result, registered
// at that edge. The top slice starts a drain of top+1 results (up to 9), one per cycle
// unless i_out_stall holds, from the window registers; input stalls during the drain and the
// window clears after its final result. Reset clears window valid bits, counts, fill, slice
// counter, total and r_out_valid. Input stalls while a held result waits on i_out_stall.
`timescale 1ns / 1ps
`default_nettype none
module slice_streak_dropout_flagger
    import ssdf_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic signed [FRAC_W-1:0] i_fraction,
    input  wire logic                    i_slice_valid,
    input  wire logic                    i_last_slice,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [SLICE_W-1:0]           o_slice_index,
    output logic [COUNT_W-1:0]           o_bad_count,
    output logic [TOTAL_W-1:0]           o_volume_bad_total,
    output logic                         o_last
);

    logic [3:0]  r_streak_length;
    logic [15:0] r_streak_threshold;
    logic [15:0] r_drop_difference;
    logic [14:0] r_drop_fraction;

    t_frac                r_frac  [WIN];
    logic   [WIN-1:0]     r_val;
    t_count               r_count [WIN];
    logic   [POS_W-1:0]   r_fill;
    logic   [SLICE_W-1:0] r_slice;
    logic   [TOTAL_W-1:0] r_total;
    logic                 r_drain;
    logic   [POS_W-1:0]   r_pos;

    logic                 r_out_valid;
    logic   [SLICE_W-1:0] r_out_index;
    t_count               r_out_count;
    logic   [TOTAL_W-1:0] r_out_total;
    logic                 r_out_last;

    t_frac                n_frac  [WIN];
    logic   [WIN-1:0]     n_val;
    t_count               n_count [WIN];
    logic   [POS_W-1:0]   n_fill;
    logic   [POS_W-1:0]   len;
    logic   [POS_W-1:0]   delay;
    logic   [POS_W-1:0]   top;
    logic   [WIN-1:1]     step_ok;
    logic                 hit;
    logic                 drop;
    logic                 emit;
    logic signed [FRAC_W:0] diff1;
    logic   [FRAC_W:0]    mag_diff1;
    logic   [FRAC_W:0]    mag_frac1;
    logic signed [FRAC_W:0] bound;
    logic                 in_acc;
    logic                 out_free;
    logic                 drain_step;
    t_count               drain_count;
    logic   [TOTAL_W-1:0] drain_total;
    logic   [TOTAL_W-1:0] emit_total;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_drain || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign drain_step = r_drain && out_free;

    always_comb begin
        logic signed [FRAC_W:0] d;
        logic [FRAC_W:0]        m;
        logic [1:0]             inc;
        len   = (r_streak_length > POS_W'(MAX_STREAK)) ? POS_W'(MAX_STREAK) : r_streak_length;
        delay = (len == '0) ? POS_W'(1) : len;
        n_fill = (r_fill == POS_W'(WIN)) ? POS_W'(WIN) : r_fill + POS_W'(1);
        top   = ((n_fill - POS_W'(1)) < delay) ? (n_fill - POS_W'(1)) : delay;

        n_frac[0] = i_fraction;
        n_val[0]  = i_slice_valid && !i_last_slice;
        for (int i = 1; i < WIN; i++) begin
            n_frac[i] = r_frac[i-1];
            n_val[i]  = r_val[i-1];
        end

        for (int i = 1; i < WIN; i++) begin
            d = (FRAC_W+1)'(n_frac[i]) - (FRAC_W+1)'(n_frac[i-1]);
            m = d[FRAC_W] ? (FRAC_W+1)'(-d) : d;
            step_ok[i] = m >= {1'b0, r_streak_threshold};
        end

        hit = (len != '0) && ({1'b0, n_fill} >= {1'b0, len} + (POS_W+1)'(1));
        for (int i = 1; i < WIN; i++) begin
            if (POS_W'(i) <= len && !(n_val[i] && step_ok[i])) begin
                hit = 1'b0;
            end
        end

        diff1     = (FRAC_W+1)'(n_frac[1]) - (FRAC_W+1)'(n_frac[0]);
        mag_diff1 = diff1[FRAC_W] ? (FRAC_W+1)'(-diff1) : diff1;
        mag_frac1 = n_frac[1][FRAC_W-1] ? (FRAC_W+1)'(-(FRAC_W+1)'(n_frac[1]))
                                        : (FRAC_W+1)'(n_frac[1]);
        bound     = (FRAC_W+1)'(HALF_Q15) - (FRAC_W+1)'({1'b0, r_drop_fraction});
        drop = (n_fill >= POS_W'(2)) && n_val[1] &&
               (($signed(mag_frac1) >= bound) || (mag_diff1 >= {1'b0, r_drop_difference}));

        n_count[0] = '0;
        for (int i = 1; i < WIN; i++) begin
            inc = 2'(((i == 1) && drop) ? 1 : 0) + 2'((hit && POS_W'(i) <= len) ? 1 : 0);
            n_count[i] = count_add(r_count[i-1], inc);
        end

        emit       = {1'b0, n_fill} >= {1'b0, delay} + (POS_W+1)'(1);
        emit_total = total_add(r_total, n_count[delay]);

        drain_count = r_count[r_pos];
        drain_total = total_add(r_total, drain_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streak_length    <= RST_STREAK_LENGTH;
            r_streak_threshold <= RST_STREAK_THRESHOLD;
            r_drop_difference  <= RST_DROP_DIFFERENCE;
            r_drop_fraction    <= RST_DROP_FRACTION;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_STREAK_LENGTH:    r_streak_length    <= i_cfg_data[3:0];
                CFG_STREAK_THRESHOLD: r_streak_threshold <= i_cfg_data;
                CFG_DROP_DIFFERENCE:  r_drop_difference  <= i_cfg_data;
                CFG_DROP_FRACTION:    r_drop_fraction    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < WIN; i++) begin
                r_frac[i] <= n_frac[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val       <= '0;
            for (int i = 0; i < WIN; i++) begin
                r_count[i] <= '0;
            end
            r_fill      <= '0;
            r_slice     <= '0;
            r_total     <= '0;
            r_drain     <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_val  <= n_val;
                for (int i = 0; i < WIN; i++) begin
                    r_count[i] <= n_count[i];
                end
                r_fill <= n_fill;
                if (i_last_slice) begin
                    r_drain     <= 1'b1;
                    r_pos       <= top;
                    r_out_valid <= 1'b0;
                end else begin
                    r_slice     <= r_slice + SLICE_W'(1);
                    r_out_valid <= emit;
                    if (emit) begin
                        r_total     <= emit_total;
                        r_out_index <= r_slice - SLICE_W'(delay);
                        r_out_count <= n_count[delay];
                        r_out_total <= '0;
                        r_out_last  <= 1'b0;
                    end
                end
            end else if (drain_step) begin
                r_out_valid <= 1'b1;
                r_out_index <= r_slice - SLICE_W'(r_pos);
                r_out_count <= drain_count;
                r_out_last  <= (r_pos == '0);
                r_out_total <= (r_pos == '0) ? drain_total : '0;
                if (r_pos == '0) begin
                    r_drain <= 1'b0;
                    r_val   <= '0;
                    for (int i = 0; i < WIN; i++) begin
                        r_count[i] <= '0;
                    end
                    r_fill  <= '0;
                    r_slice <= '0;
                    r_total <= '0;
                end else begin
                    r_total <= drain_total;
                    r_pos   <= r_pos - POS_W'(1);
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_slice_index      = r_out_index;
    assign o_bad_count        = r_out_count;
    assign o_volume_bad_total = r_out_total;
    assign o_last             = r_out_last;

    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_slice |=> r_drain)
        else $error("top slice did not start a drain");

    a_drain_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_step && r_pos == '0 |=> o_out_valid && o_last && !r_drain && r_fill == '0)
        else $error("drain did not end on the last word");

    a_total_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_volume_bad_total == '0)
        else $error("volume total on a word that is not last");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= POS_W'(WIN) && r_pos <= POS_W'(MAX_STREAK))
        else $error("window fill or drain position out of range");

endmodule
`default_nettype wire
